// ===== src/space_vector_pwm_compare_core_assert.svh =====
// Assertion macros for the space vector PWM compare core.
// SVPC_ASSERT_IMP checks in the same cycle, SVPC_ASSERT_NXT in the cycle after.
`ifndef SPACE_VECTOR_PWM_COMPARE_CORE_ASSERT_SVH
`define SPACE_VECTOR_PWM_COMPARE_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SVPC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("svpc: assertion failed");
`define SVPC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("svpc: assertion failed");
`else
`define SVPC_ASSERT_IMP(lbl, ante, cons)
`define SVPC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== src/svpc_pkg.sv =====
package svpc_pkg;

	localparam int VW = 16;
	localparam int CW = 16;

	localparam int KW = 17;
	localparam logic [KW-1:0] HALF_SQRT3_Q16   = 17'd56756;
	localparam logic [KW-1:0] THREE_HALVES_Q16 = 17'd98304;

	// edge values and active times
	localparam int FW  = VW + 19;
	// squared magnitudes
	localparam int SQW = 2 * VW;
	// period expressed as vdc << D_SHIFT
	localparam int D_SHIFT   = 16;
	localparam int DIV_SHIFT = D_SHIFT + 1;
	// clamped doubled on-times, 0..2d
	localparam int XW = VW + DIV_SHIFT;
	// signed sums around d
	localparam int SW = VW + 21;
	// on-time times period
	localparam int PW = XW + CW;
	// divider word: remainder on top, dividend / quotient below
	localparam int NW = VW + CW;

	localparam int DIV_PER_STG = 2;
	localparam int DIV_STGS    = (CW + DIV_PER_STG - 1) / DIV_PER_STG;
	localparam int FRONT_STGS  = 6;
	localparam int NSTG        = FRONT_STGS + DIV_STGS;

	localparam int SECW = 3;
	localparam logic [SECW-1:0] SEC_1 = 3'd1;
	localparam logic [SECW-1:0] SEC_2 = 3'd2;
	localparam logic [SECW-1:0] SEC_3 = 3'd3;
	localparam logic [SECW-1:0] SEC_4 = 3'd4;
	localparam logic [SECW-1:0] SEC_5 = 3'd5;
	localparam logic [SECW-1:0] SEC_6 = 3'd6;

	typedef logic [CW-1:0] count_t;
	typedef logic signed [VW-1:0] volt_t;
	typedef logic [VW-1:0] uvolt_t;

	typedef struct packed {
		logic [2:0][NW-1:0] w;
		uvolt_t             vdc;
		logic [SECW-1:0]    sec;
		logic               om;
		logic               zero;
	} div_stage_t;

	typedef struct packed {
		count_t          compare_a;
		count_t          compare_b;
		count_t          compare_c;
		logic [SECW-1:0] sector;
		logic            overmodulation;
	} result_t;

	// One restoring division step: the top VW bits hold a remainder below dv.
	function automatic logic [NW-1:0] div_step(input logic [NW-1:0] w, input uvolt_t dv);
		logic [VW:0] part;
		logic [VW:0] diff;
		logic        ge;
		part = w[NW-1:CW-1];
		diff = part - {1'b0, dv};
		ge   = (part >= {1'b0, dv});
		return {(ge ? diff[VW-1:0] : part[VW-1:0]), w[CW-2:0], ge};
	endfunction

	function automatic div_stage_t div_pass(input div_stage_t st, input int first);
		div_stage_t r;
		r = st;
		for (int j = 0; j < DIV_PER_STG; j++) begin
			if (first + j < CW) begin
				for (int l = 0; l < 3; l++) begin
					r.w[l] = div_step(r.w[l], r.vdc);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [XW-1:0] clamp2(input logic signed [SW-1:0] x,
			input logic signed [SW-1:0] top);
		if (x < 0) begin
			return '0;
		end else if (x > top) begin
			return top[XW-1:0];
		end
		return x[XW-1:0];
	endfunction

endpackage

// ===== src/svpc_in_if.sv =====
interface svpc_in_if;
	logic            valid;
	logic            ready;
	svpc_pkg::volt_t  alpha_voltage;
	svpc_pkg::volt_t  beta_voltage;
	svpc_pkg::uvolt_t dc_voltage;

	modport source (
		output valid,
		output alpha_voltage,
		output beta_voltage,
		output dc_voltage,
		input  ready
	);

	modport sink (
		input  valid,
		input  alpha_voltage,
		input  beta_voltage,
		input  dc_voltage,
		output ready
	);
endinterface

// ===== src/svpc_out_if.sv =====
interface svpc_out_if;
	logic                         valid;
	logic                         ready;
	svpc_pkg::count_t             compare_a;
	svpc_pkg::count_t             compare_b;
	svpc_pkg::count_t             compare_c;
	logic [svpc_pkg::SECW-1:0]    sector;
	logic                         overmodulation;

	modport source (
		output valid,
		output compare_a,
		output compare_b,
		output compare_c,
		output sector,
		output overmodulation,
		input  ready
	);

	modport sink (
		input  valid,
		input  compare_a,
		input  compare_b,
		input  compare_c,
		input  sector,
		input  overmodulation,
		output ready
	);
endinterface

// ===== src/space_vector_pwm_compare_core.sv =====
// Path from an input transfer to rsp: six arithmetic stages, eight divider stages
// resolving two quotient bits each, one output register. Throughput: one item per
// cycle while the skid entry is empty; the three-lane restoring divider is fully
// pipelined. A two-entry output buffer keeps req.ready high while one result waits on
// rsp. Reset (arst_n low) zeroes all valid bits, the buffer's too, and period_q.
`include "space_vector_pwm_compare_core_assert.svh"
module space_vector_pwm_compare_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  svpc_pkg::count_t  cfg_wdata,
	svpc_in_if.sink           req,
	svpc_out_if.source        rsp
);

	localparam int FW  = svpc_pkg::FW;
	localparam int SQW = svpc_pkg::SQW;
	localparam int SW  = svpc_pkg::SW;
	localparam int XW  = svpc_pkg::XW;
	localparam int PW  = svpc_pkg::PW;
	localparam int VW  = svpc_pkg::VW;
	localparam int CW  = svpc_pkg::CW;
	localparam int NS  = svpc_pkg::NSTG;
	localparam int DS  = svpc_pkg::DIV_STGS;

	svpc_pkg::count_t period_q;

	logic [NS-1:0] vld_sn;
	logic          adv;
	logic          take;

	// stage 1: magnitudes squared and constant products
	svpc_pkg::volt_t         u_s1, v_s1;
	svpc_pkg::uvolt_t        vdc_s1;
	logic [SQW-1:0]          au2_s1, av2_s1;
	logic signed [FW-1:0]    c_s1, s_s1;
	// stage 2: sector and edge values
	logic [svpc_pkg::SECW-1:0] sec_s2;
	logic signed [FW-1:0]    f0_s2, f60_s2, f120_s2;
	svpc_pkg::uvolt_t        vdc_s2;
	// stage 3: active times
	logic [svpc_pkg::SECW-1:0] sec_s3;
	logic signed [FW-1:0]    ta_s3, tb_s3;
	svpc_pkg::uvolt_t        vdc_s3;
	logic                    zero_s3;
	// stage 4: clamped doubled on-times
	logic [svpc_pkg::SECW-1:0] sec_s4;
	logic [XW-1:0]           hi_s4, lo_s4, xa_s4, xb_s4;
	svpc_pkg::uvolt_t        vdc_s4;
	logic                    zero_s4, om_s4;
	// stage 5: per-phase selection
	logic [svpc_pkg::SECW-1:0] sec_s5;
	logic [XW-1:0]           ea_s5, eb_s5, ec_s5;
	svpc_pkg::uvolt_t        vdc_s5;
	logic                    zero_s5, om_s5;
	// stage 6 and divider stages
	svpc_pkg::div_stage_t    dv_s6;
	svpc_pkg::div_stage_t    dv_sn [DS];
	svpc_pkg::div_stage_t    dv_nx [DS];

	// output buffer
	svpc_pkg::result_t out_q, skid_q, res_c;
	logic              out_v_q, skv_q;

	// combinational signals
	svpc_pkg::uvolt_t        au_c, av_c;
	logic signed [FW-1:0]    ux_c, vx_c;
	logic [SQW-1:0]          uu3_c;
	logic                    upper_c;
	logic [svpc_pkg::SECW-1:0] sec_c;
	logic signed [FW-1:0]    ta_c, tb_c;
	logic signed [SW-1:0]    d_c, d2_c, tax_c, tbx_c;
	logic [XW-1:0]           ea_c, eb_c, ec_c;
	logic [PW-1:0]           pa_c, pb_c, pc_c;
	svpc_pkg::div_stage_t    dv6_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
		end else if (cfg_we) begin
			period_q <= cfg_wdata;
		end
	end

	// the whole pipe holds only while the skid entry is occupied
	assign adv       = !skv_q;
	assign req.ready = adv;
	assign take      = vld_sn[NS-1] && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sn <= '0;
		end else if (adv) begin
			vld_sn <= {vld_sn[NS-2:0], req.valid};
		end
	end

	// stage 1
	always_comb begin
		au_c = req.alpha_voltage[VW-1] ? VW'(~req.alpha_voltage + 1'b1) : VW'(req.alpha_voltage);
		av_c = req.beta_voltage[VW-1] ? VW'(~req.beta_voltage + 1'b1) : VW'(req.beta_voltage);
		ux_c = FW'(req.alpha_voltage);
		vx_c = FW'(req.beta_voltage);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			u_s1   <= req.alpha_voltage;
			v_s1   <= req.beta_voltage;
			vdc_s1 <= req.dc_voltage;
			au2_s1 <= SQW'(au_c) * SQW'(au_c);
			av2_s1 <= SQW'(av_c) * SQW'(av_c);
			c_s1   <= ux_c * $signed(FW'(svpc_pkg::THREE_HALVES_Q16));
			s_s1   <= vx_c * $signed(FW'(svpc_pkg::HALF_SQRT3_Q16));
		end
	end

	// stage 2: sector from signs and beta^2 against 3*alpha^2
	always_comb begin
		uu3_c   = au2_s1 + {au2_s1[SQW-2:0], 1'b0};
		upper_c = (v_s1 > 0) || (v_s1 == 0 && u_s1 >= 0);
		priority if (u_s1 == 0 && v_s1 == 0) begin
			sec_c = svpc_pkg::SEC_1;
		end else if (upper_c) begin
			priority if (u_s1 > 0 && av2_s1 < uu3_c) begin
				sec_c = svpc_pkg::SEC_1;
			end else if (u_s1 < 0 && av2_s1 <= uu3_c) begin
				sec_c = svpc_pkg::SEC_3;
			end else begin
				sec_c = svpc_pkg::SEC_2;
			end
		end else begin
			priority if (u_s1 < 0 && av2_s1 < uu3_c) begin
				sec_c = svpc_pkg::SEC_4;
			end else if (u_s1 > 0 && av2_s1 <= uu3_c) begin
				sec_c = svpc_pkg::SEC_6;
			end else begin
				sec_c = svpc_pkg::SEC_5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s2  <= sec_c;
			f0_s2   <= -(s_s1 + s_s1);
			f60_s2  <= c_s1 - s_s1;
			f120_s2 <= c_s1 + s_s1;
			vdc_s2  <= vdc_s1;
		end
	end

	// stage 3: pick the sector's pair of edges, drop negative times
	always_comb begin
		unique case (sec_s2)
			svpc_pkg::SEC_1: begin ta_c = f60_s2;   tb_c = -f0_s2;   end
			svpc_pkg::SEC_2: begin ta_c = f120_s2;  tb_c = -f60_s2;  end
			svpc_pkg::SEC_3: begin ta_c = -f0_s2;   tb_c = -f120_s2; end
			svpc_pkg::SEC_4: begin ta_c = -f60_s2;  tb_c = f0_s2;    end
			svpc_pkg::SEC_5: begin ta_c = -f120_s2; tb_c = f60_s2;   end
			default:         begin ta_c = f0_s2;    tb_c = f120_s2;  end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s3  <= sec_s2;
			ta_s3   <= ta_c[FW-1] ? '0 : ta_c;
			tb_s3   <= tb_c[FW-1] ? '0 : tb_c;
			vdc_s3  <= vdc_s2;
			zero_s3 <= (vdc_s2 == '0) || (period_q == '0);
		end
	end

	// stage 4
	always_comb begin
		d_c   = $signed(SW'({vdc_s3, {svpc_pkg::D_SHIFT{1'b0}}}));
		d2_c  = d_c + d_c;
		tax_c = SW'(ta_s3);
		tbx_c = SW'(tb_s3);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s4  <= sec_s3;
			hi_s4   <= svpc_pkg::clamp2(d_c + tax_c + tbx_c, d2_c);
			lo_s4   <= svpc_pkg::clamp2(d_c - tax_c - tbx_c, d2_c);
			xa_s4   <= svpc_pkg::clamp2(d_c + tax_c - tbx_c, d2_c);
			xb_s4   <= svpc_pkg::clamp2(d_c - tax_c + tbx_c, d2_c);
			vdc_s4  <= vdc_s3;
			zero_s4 <= zero_s3;
			om_s4   <= !zero_s3 && (tax_c + tbx_c > d_c);
		end
	end

	// stage 5
	always_comb begin
		unique case (sec_s4)
			svpc_pkg::SEC_1: begin ea_c = hi_s4; eb_c = xb_s4; ec_c = lo_s4; end
			svpc_pkg::SEC_2: begin ea_c = xa_s4; eb_c = hi_s4; ec_c = lo_s4; end
			svpc_pkg::SEC_3: begin ea_c = lo_s4; eb_c = hi_s4; ec_c = xb_s4; end
			svpc_pkg::SEC_4: begin ea_c = lo_s4; eb_c = xa_s4; ec_c = hi_s4; end
			svpc_pkg::SEC_5: begin ea_c = xb_s4; eb_c = lo_s4; ec_c = hi_s4; end
			default:         begin ea_c = hi_s4; eb_c = lo_s4; ec_c = xa_s4; end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s5  <= sec_s4;
			ea_s5   <= ea_c;
			eb_s5   <= eb_c;
			ec_s5   <= ec_c;
			vdc_s5  <= vdc_s4;
			zero_s5 <= zero_s4;
			om_s5   <= om_s4;
		end
	end

	// stage 6: x*period / (vdc << 17) becomes (x*period >> 17) / vdc
	always_comb begin
		pa_c      = PW'(ea_s5) * PW'(period_q);
		pb_c      = PW'(eb_s5) * PW'(period_q);
		pc_c      = PW'(ec_s5) * PW'(period_q);
		dv6_c.w[0] = pa_c[PW-1:svpc_pkg::DIV_SHIFT];
		dv6_c.w[1] = pb_c[PW-1:svpc_pkg::DIV_SHIFT];
		dv6_c.w[2] = pc_c[PW-1:svpc_pkg::DIV_SHIFT];
		dv6_c.vdc  = vdc_s5;
		dv6_c.sec  = sec_s5;
		dv6_c.om   = om_s5;
		dv6_c.zero = zero_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s6 <= dv6_c;
		end
	end

	// divider stages
	always_comb begin
		dv_nx[0] = svpc_pkg::div_pass(dv_s6, 0);
		for (int k = 1; k < DS; k++) begin
			dv_nx[k] = svpc_pkg::div_pass(dv_sn[k-1], k * svpc_pkg::DIV_PER_STG);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < DS; k++) begin
				dv_sn[k] <= dv_nx[k];
			end
		end
	end

	always_comb begin
		res_c.compare_a      = dv_sn[DS-1].zero ? '0 : dv_sn[DS-1].w[0][CW-1:0];
		res_c.compare_b      = dv_sn[DS-1].zero ? '0 : dv_sn[DS-1].w[1][CW-1:0];
		res_c.compare_c      = dv_sn[DS-1].zero ? '0 : dv_sn[DS-1].w[2][CW-1:0];
		res_c.sector         = dv_sn[DS-1].sec;
		res_c.overmodulation = dv_sn[DS-1].om;
	end

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skv_q   <= 1'b0;
		end else if (out_v_q && rsp.ready) begin
			if (skv_q) begin
				out_v_q <= 1'b1;
				skv_q   <= 1'b0;
			end else begin
				out_v_q <= take;
			end
		end else if (!out_v_q) begin
			out_v_q <= take;
		end else if (take) begin
			skv_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || rsp.ready) begin
			out_q <= skv_q ? skid_q : res_c;
		end
		if (out_v_q && !rsp.ready && take) begin
			skid_q <= res_c;
		end
	end

	assign rsp.valid          = out_v_q;
	assign rsp.compare_a      = out_q.compare_a;
	assign rsp.compare_b      = out_q.compare_b;
	assign rsp.compare_c      = out_q.compare_c;
	assign rsp.sector         = out_q.sector;
	assign rsp.overmodulation = out_q.overmodulation;

	`SVPC_ASSERT_IMP(a_skid_needs_out, skv_q, out_v_q)
	`SVPC_ASSERT_NXT(a_skid_drain, skv_q && rsp.ready, out_v_q && !skv_q)
	`SVPC_ASSERT_IMP(a_sector_range, rsp.valid, rsp.sector >= svpc_pkg::SEC_1 && rsp.sector <= svpc_pkg::SEC_6)
	`SVPC_ASSERT_IMP(a_om_phase_low, rsp.valid && rsp.overmodulation, rsp.compare_a == '0 || rsp.compare_b == '0 || rsp.compare_c == '0)
	`SVPC_ASSERT_IMP(a_sec1_order, rsp.valid && rsp.sector == svpc_pkg::SEC_1, rsp.compare_a >= rsp.compare_b && rsp.compare_b >= rsp.compare_c)

endmodule

// ===== dv/svpc_compare_checker.sv =====
`timescale 1ns / 100ps
module svpc_compare_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  svpc_pkg::count_t cfg_wdata,
	svpc_in_if               req,
	svpc_out_if              rsp,
	output int               mismatches,
	output int               outstanding
);

	svpc_pkg::count_t  period_now = '0;
	svpc_pkg::result_t expected_compares[$];
	svpc_pkg::result_t want;

	task automatic report_mismatch(input string what, input longint got, input longint exp_val);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
		mismatches++;
	endtask

	function automatic longint clip_doubled(input longint x, input longint top);
		if (x < 0) begin
			return 0;
		end else if (x > top) begin
			return top;
		end
		return x;
	endfunction

	function automatic svpc_pkg::result_t compute_compares(input svpc_pkg::volt_t alpha,
			input svpc_pkg::volt_t beta, input svpc_pkg::uvolt_t vdc,
			input svpc_pkg::count_t period);
		svpc_pkg::result_t         r;
		longint                    u, v, au, av, uu3, vv, c, s, f0, f60, f120;
		longint                    ta, tb, d, hi, lo, xa, xb, ea, eb, ec;
		logic                      upper;
		logic [svpc_pkg::SECW-1:0] sec;
		u     = alpha;
		v     = beta;
		au    = (u < 0) ? -u : u;
		av    = (v < 0) ? -v : v;
		uu3   = 3 * au * au;
		vv    = av * av;
		c     = longint'(svpc_pkg::THREE_HALVES_Q16) * u;
		s     = longint'(svpc_pkg::HALF_SQRT3_Q16) * v;
		f0    = -2 * s;
		f60   = c - s;
		f120  = c + s;
		upper = (v > 0) || (v == 0 && u >= 0);

		// exact sector search: compare beta^2 against 3*alpha^2 instead of the angle
		if (u == 0 && v == 0) begin
			sec = svpc_pkg::SEC_1;
		end else if (upper) begin
			if (u > 0 && vv < uu3) sec = svpc_pkg::SEC_1;
			else if (u < 0 && vv <= uu3) sec = svpc_pkg::SEC_3;
			else sec = svpc_pkg::SEC_2;
		end else begin
			if (u < 0 && vv < uu3) sec = svpc_pkg::SEC_4;
			else if (u > 0 && vv <= uu3) sec = svpc_pkg::SEC_6;
			else sec = svpc_pkg::SEC_5;
		end

		unique case (sec)
			svpc_pkg::SEC_1: begin ta = f60;   tb = -f0;   end
			svpc_pkg::SEC_2: begin ta = f120;  tb = -f60;  end
			svpc_pkg::SEC_3: begin ta = -f0;   tb = -f120; end
			svpc_pkg::SEC_4: begin ta = -f60;  tb = f0;    end
			svpc_pkg::SEC_5: begin ta = -f120; tb = f60;   end
			default: begin ta = f0;  tb = f120;  end
		endcase
		if (ta < 0) ta = 0;
		if (tb < 0) tb = 0;

		r = '0;
		r.sector = sec;
		if (vdc != 0 && period != 0) begin
			d  = longint'(vdc) << 16;
			r.overmodulation = (ta + tb > d);
			hi = clip_doubled(d + ta + tb, 2 * d);
			lo = clip_doubled(d - ta - tb, 2 * d);
			xa = clip_doubled(d + ta - tb, 2 * d);
			xb = clip_doubled(d - ta + tb, 2 * d);
			unique case (sec)
				svpc_pkg::SEC_1: begin ea = hi; eb = xb; ec = lo; end
				svpc_pkg::SEC_2: begin ea = xa; eb = hi; ec = lo; end
				svpc_pkg::SEC_3: begin ea = lo; eb = hi; ec = xb; end
				svpc_pkg::SEC_4: begin ea = lo; eb = xa; ec = hi; end
				svpc_pkg::SEC_5: begin ea = xb; eb = lo; ec = hi; end
				default: begin ea = hi; eb = lo; ec = xa; end
			endcase
			r.compare_a = svpc_pkg::count_t'((ea * longint'(period)) / (2 * d));
			r.compare_b = svpc_pkg::count_t'((eb * longint'(period)) / (2 * d));
			r.compare_c = svpc_pkg::count_t'((ec * longint'(period)) / (2 * d));
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			period_now = '0;
			mismatches = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_compares.size() == 0) begin
					report_mismatch("result with nothing pending, sector", rsp.sector, 0);
				end else begin
					want = expected_compares.pop_front();
					if (rsp.compare_a !== want.compare_a)
						report_mismatch("compare_a", rsp.compare_a, want.compare_a);
					if (rsp.compare_b !== want.compare_b)
						report_mismatch("compare_b", rsp.compare_b, want.compare_b);
					if (rsp.compare_c !== want.compare_c)
						report_mismatch("compare_c", rsp.compare_c, want.compare_c);
					if (rsp.sector !== want.sector)
						report_mismatch("sector", rsp.sector, want.sector);
					if (rsp.overmodulation !== want.overmodulation)
						report_mismatch("overmodulation", rsp.overmodulation,
							want.overmodulation);
				end
			end
			if (req.valid && req.ready)
				expected_compares.push_back(compute_compares(req.alpha_voltage,
					req.beta_voltage, req.dc_voltage, period_now));
			// a register write lands after any transfer sampled on the same edge
			if (cfg_we)
				period_now = cfg_wdata;
		end
		outstanding = expected_compares.size();
	end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	svpc_pkg::count_t cfg_wdata;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               mismatches;
	int               outstanding;
	svpc_pkg::count_t phase_period [8] = '{16'd65535, 16'd1, 16'd0, 16'd1000,
		16'd2, 16'd40000, 16'd3, 16'd65535};

	svpc_in_if  req_if();
	svpc_out_if rsp_if();

	space_vector_pwm_compare_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_if),
		.rsp       (rsp_if)
	);

	svpc_compare_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req_if),
		.rsp         (rsp_if),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_reference(input svpc_pkg::volt_t alpha, input svpc_pkg::volt_t beta,
			input svpc_pkg::uvolt_t vdc);
		while ($urandom_range(99) < send_idle_pct) begin
			req_if.valid = 1'b0;
			@(negedge clk);
		end
		req_if.valid         = 1'b1;
		req_if.alpha_voltage = alpha;
		req_if.beta_voltage  = beta;
		req_if.dc_voltage    = vdc;
		do @(posedge clk); while (!req_if.ready);
		// hold valid into the next call so back-to-back transfers stay back to back
		@(negedge clk);
	endtask

	task automatic random_reference();
		int               mode;
		int               lim;
		svpc_pkg::volt_t  alpha;
		svpc_pkg::volt_t  beta;
		svpc_pkg::uvolt_t vdc;
		mode  = $urandom_range(15);
		vdc   = svpc_pkg::uvolt_t'($urandom_range(65535, 1));
		alpha = svpc_pkg::volt_t'($urandom);
		beta  = svpc_pkg::volt_t'($urandom);
		if (mode >= 2) begin
			// mostly inside the hexagon, some way past it
			lim   = vdc >> 1;
			alpha = svpc_pkg::volt_t'(int'($urandom_range(2 * lim)) - lim);
			beta  = svpc_pkg::volt_t'(int'($urandom_range(2 * lim)) - lim);
		end
		if (mode == 0) vdc = '0;
		if (mode == 2) alpha = '0;
		if (mode == 3) beta = '0;
		send_reference(alpha, beta, vdc);
	endtask

	task automatic wait_results_drained();
		req_if.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_period(input svpc_pkg::count_t value);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	initial begin
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		req_if.valid         = 1'b0;
		req_if.alpha_voltage = '0;
		req_if.beta_voltage  = '0;
		req_if.dc_voltage    = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// period still at its reset value of zero
		send_reference(16'sd1000, 16'sd500, 16'd2000);
		send_reference(-16'sd700, -16'sd300, 16'd2000);
		wait_results_drained();
		write_period(16'd40000);

		send_reference(16'sd0, 16'sd0, 16'd1000);
		send_reference(16'sd1000, 16'sd0, 16'd2000);
		send_reference(16'sd0, 16'sd1000, 16'd2000);
		send_reference(-16'sd1000, 16'sd0, 16'd2000);
		send_reference(16'sd0, -16'sd1000, 16'd2000);
		send_reference(16'sd500, 16'sd866, 16'd2000);
		send_reference(-16'sd500, 16'sd866, 16'd2000);
		send_reference(-16'sd500, -16'sd866, 16'd2000);
		send_reference(16'sd500, -16'sd866, 16'd2000);
		send_reference(16'sd1000, 16'sd577, 16'd2000);
		send_reference(16'sd32767, 16'sd32767, 16'd65535);
		send_reference(-16'sd32768, -16'sd32768, 16'd65535);
		send_reference(-16'sd32768, 16'sd32767, 16'd65535);
		send_reference(16'sd32767, -16'sd32768, 16'd1);
		send_reference(16'sd32767, 16'sd0, 16'd1);
		send_reference(16'sd300, 16'sd200, 16'd0);
		send_reference(-16'sd1, -16'sd1, 16'd65535);
		send_reference(16'sd1, -16'sd1, 16'd1);

		for (int phase = 0; phase < 8; phase++) begin
			wait_results_drained();
			write_period((phase == 6) ? svpc_pkg::count_t'($urandom) : phase_period[phase]);
			case (phase % 4)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 51; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 51; end
				default: begin send_idle_pct = 6; stall_pct = 6; end
			endcase
			for (int n = 0; n < 116; n++) begin
				if (phase == 5 && n == 58)
					wait_results_drained();
				random_reference();
			end
		end

		req_if.valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
